// ===== rtl/core/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg: shared types for the max-timeslice task scheduler
// beat payloads, slot table entry, function and error codes, sequencer states
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int IDLE_SLOT = 0;

   localparam logic [2:0] FUNC_SET  = 3'd0;
   localparam logic [2:0] FUNC_ENQ  = 3'd1;
   localparam logic [2:0] FUNC_DEQ  = 3'd2;
   localparam logic [2:0] FUNC_PICK = 3'd3;
   localparam logic [2:0] FUNC_TICK = 3'd4;

   localparam logic [1:0] ERR_OK       = 2'd0;
   localparam logic [1:0] ERR_ENQ_BAD  = 2'd1;
   localparam logic [1:0] ERR_DEQ_BAD  = 2'd2;
   localparam logic [1:0] ERR_Q_FULL   = 2'd3;

   typedef struct packed {
      logic [2:0] func;
      logic [5:0] task_id;
      logic [6:0] priority_req;
      logic [7:0] slice_value;
      logic       in_use;
   } req_type;

   typedef struct packed {
      logic [5:0] chosen_task;
      logic [7:0] chosen_slice;
      logic       expired;
      logic [5:0] ready_count;
      logic [1:0] error_code;
   } rsp_type;

   typedef struct packed {
      logic       used;
      logic [6:0] prio;
      logic [7:0] slice;
   } slot_entry_type;

   localparam slot_entry_type SLOT_RESET = '{used: 1'b0, prio: 7'd1, slice: 8'd0};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SHIFT,
      ST_RECHARGE,
      ST_IDLE_RD,
      ST_IDLE_WR,
      ST_TICK_WR
   } state_type;

endpackage

// ===== rtl/core/mts_table.sv =====
// ----------------------------------------------------------------------------
// mts_table: per-task slot table
// one write and one registered read port, per-entry valid bits give reset value
// ----------------------------------------------------------------------------
module mts_table import mts_pkg::*; #(
   parameter int TASK_SLOTS = 64,
   parameter int SLOT_W     = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [SLOT_W-1:0]     wr_addr,
   input  slot_entry_type        wr_data,
   input  logic [SLOT_W-1:0]     rd_addr,
   output slot_entry_type        rd_data
);

   slot_entry_type          mem [TASK_SLOTS];
   logic [TASK_SLOTS-1:0]   vld_ff;
   slot_entry_type          mem_q_ff;
   logic                    vld_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         vld_q_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         vld_q_ff <= vld_ff[rd_addr];
      end
   end

   // entry never written reads as its reset value
   assign rd_data = vld_q_ff ? mem_q_ff : SLOT_RESET;

endmodule

// ===== rtl/core/max_timeslice_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// max_timeslice_task_scheduler: table-driven scheduler with ordered ready queue
// set_task, enqueue, dequeue, pick (largest slice, recharge) and tick
// ----------------------------------------------------------------------------
// One request beat in, one response beat out, one request at a time. A request
// is taken when the sequencer is idle and the response register is empty.
// Dequeue and pick walk the ready queue through a 3-stage read pipeline
// (queue memory, then slot table), then close the gap in the queue with a
// read-ahead copy loop. A pick that finds only zero slices sweeps the slot
// table once (one entry a cycle through the single table port) and scans
// again. The queue memory and the slot table each have one read and one
// write port and set the pace.
module max_timeslice_task_scheduler import mts_pkg::*; #(
   parameter int TASK_SLOTS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int QDEPTH = 64;
   localparam int QCAP_I = (TASK_SLOTS - 1 < 63) ? (TASK_SLOTS - 1) : 63;
   localparam logic [5:0]  QCAP     = 6'(QCAP_I);
   localparam logic [8:0]  SLOTS_9  = 9'(TASK_SLOTS);
   localparam logic [SLOT_W:0] SLOTS_RC = (SLOT_W+1)'(TASK_SLOTS);
   localparam logic [SLOT_W:0] RC_ONE   = (SLOT_W+1)'(1);

   // sequencer and latched request
   state_type state_ff, state_in;
   req_type   req_ff;
   logic      req_accept;

   // queue bookkeeping
   logic [5:0]            len_ff, len_in;
   logic [TASK_SLOTS-1:0] queued_ff, queued_in;
   logic [5:0]            idx_ff, idx_in;
   logic [SLOT_W:0]       rc_idx_ff, rc_idx_in;
   logic                  recharged_ff, recharged_in;

   // scan pipeline
   logic       s1_vld_ff, s1_vld_in;
   logic [5:0] s1_pos_ff, s1_pos_in;
   logic       s2_vld_ff, s2_vld_in;
   logic [5:0] s2_pos_ff, s2_pos_in;
   logic [5:0] s2_id_ff, s2_id_in;
   logic       best_fnd_ff, best_fnd_in;
   logic [7:0] best_slc_ff, best_slc_in;
   logic [5:0] best_pos_ff, best_pos_in;
   logic [5:0] best_id_ff, best_id_in;

   // recharge and shift pipelines
   logic              rc_vld_ff, rc_vld_in;
   logic [SLOT_W-1:0] rc_addr_ff, rc_addr_in;
   logic              sh_vld_ff, sh_vld_in;
   logic [5:0]        sh_wpos_ff, sh_wpos_in;

   // ready queue memory
   logic [5:0] ord_mem [QDEPTH];
   logic [5:0] ord_q_ff;
   logic [5:0] ord_rd_addr;
   logic       ord_wr_en;
   logic [5:0] ord_wr_addr;
   logic [5:0] ord_wr_data;

   // slot table port
   logic [SLOT_W-1:0] tbl_rd_addr;
   slot_entry_type    tbl_rd_data;
   logic              tbl_wr_en;
   logic [SLOT_W-1:0] tbl_wr_addr;
   slot_entry_type    tbl_wr_data;

   // response
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    finish;

   logic              id_valid;
   logic [SLOT_W-1:0] sid;
   logic              issue;

   assign req_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign id_valid = ({3'b000, req_ff.task_id} < SLOTS_9);
   assign sid      = SLOT_W'(req_ff.task_id);

   mts_table #(
      .TASK_SLOTS (TASK_SLOTS),
      .SLOT_W     (SLOT_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // queue memory, contents undefined until enqueued
   always_ff @(posedge clock) begin
      if (ord_wr_en) begin
         ord_mem[ord_wr_addr] <= ord_wr_data;
      end
      ord_q_ff <= ord_mem[ord_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         queued_ff    <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rc_vld_ff    <= 1'b0;
         sh_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         queued_ff <= queued_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         rc_vld_ff <= rc_vld_in;
         sh_vld_ff <= sh_vld_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
      idx_ff       <= idx_in;
      rc_idx_ff    <= rc_idx_in;
      recharged_ff <= recharged_in;
      s1_pos_ff    <= s1_pos_in;
      s2_pos_ff    <= s2_pos_in;
      s2_id_ff     <= s2_id_in;
      best_fnd_ff  <= best_fnd_in;
      best_slc_ff  <= best_slc_in;
      best_pos_ff  <= best_pos_in;
      best_id_ff   <= best_id_in;
      rc_addr_ff   <= rc_addr_in;
      sh_wpos_ff   <= sh_wpos_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      queued_in    = queued_ff;
      idx_in       = idx_ff;
      rc_idx_in    = rc_idx_ff;
      recharged_in = recharged_ff;
      s1_vld_in    = 1'b0;
      s1_pos_in    = s1_pos_ff;
      s2_vld_in    = 1'b0;
      s2_pos_in    = s2_pos_ff;
      s2_id_in     = s2_id_ff;
      best_fnd_in  = best_fnd_ff;
      best_slc_in  = best_slc_ff;
      best_pos_in  = best_pos_ff;
      best_id_in   = best_id_ff;
      rc_vld_in    = 1'b0;
      rc_addr_in   = rc_addr_ff;
      sh_vld_in    = 1'b0;
      sh_wpos_in   = sh_wpos_ff;
      ord_rd_addr  = idx_ff;
      ord_wr_en    = 1'b0;
      ord_wr_addr  = len_ff;
      ord_wr_data  = req_ff.task_id;
      tbl_rd_addr  = sid;
      tbl_wr_en    = 1'b0;
      tbl_wr_addr  = sid;
      tbl_wr_data  = tbl_rd_data;
      finish       = 1'b0;
      rsp_in       = '0;
      issue        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            case (req_ff.func)
               FUNC_SET: begin
                  if (id_valid) begin
                     tbl_wr_en         = 1'b1;
                     tbl_wr_data.used  = req_ff.in_use;
                     tbl_wr_data.prio  = (req_ff.priority_req == 7'd0) ? 7'd1
                                                                       : req_ff.priority_req;
                     tbl_wr_data.slice = req_ff.slice_value;
                  end
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
               FUNC_ENQ: begin
                  if (!id_valid || (req_ff.task_id == 6'(IDLE_SLOT)) || queued_ff[sid]) begin
                     rsp_in.error_code = ERR_ENQ_BAD;
                  end else if (len_ff >= QCAP) begin
                     rsp_in.error_code = ERR_Q_FULL;
                  end else begin
                     ord_wr_en      = 1'b1;
                     queued_in[sid] = 1'b1;
                     len_in         = len_ff + 6'd1;
                  end
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
               FUNC_DEQ: begin
                  if (!id_valid || !queued_ff[sid]) begin
                     rsp_in.error_code = ERR_DEQ_BAD;
                     finish            = 1'b1;
                     state_in          = ST_IDLE;
                  end else begin
                     idx_in      = '0;
                     best_fnd_in = 1'b0;
                     best_slc_in = '0;
                     state_in    = ST_SCAN;
                  end
               end
               FUNC_PICK: begin
                  recharged_in = 1'b0;
                  if (len_ff == 6'd0) begin
                     // empty queue: idle task, read its entry now
                     tbl_rd_addr = SLOT_W'(IDLE_SLOT);
                     state_in    = ST_IDLE_WR;
                  end else begin
                     idx_in      = '0;
                     best_fnd_in = 1'b0;
                     best_slc_in = '0;
                     state_in    = ST_SCAN;
                  end
               end
               FUNC_TICK: begin
                  if (id_valid) begin
                     state_in = ST_TICK_WR;
                  end else begin
                     finish   = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  finish   = 1'b1;
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_SCAN: begin
            // stage 0: queue read, stage 1: table read, stage 2: compare
            issue       = (idx_ff < len_ff);
            ord_rd_addr = idx_ff;
            if (issue) begin
               idx_in = idx_ff + 6'd1;
            end
            s1_vld_in   = issue;
            s1_pos_in   = idx_ff;
            tbl_rd_addr = SLOT_W'(ord_q_ff);
            s2_vld_in   = s1_vld_ff;
            s2_pos_in   = s1_pos_ff;
            s2_id_in    = ord_q_ff;
            if (req_ff.func == FUNC_DEQ) begin
               if (s1_vld_ff && (ord_q_ff == req_ff.task_id)) begin
                  best_fnd_in = 1'b1;
                  best_pos_in = s1_pos_ff;
                  best_id_in  = ord_q_ff;
               end
            end else if (s2_vld_ff && (tbl_rd_data.slice > best_slc_ff)) begin
               // strict compare keeps the first of equal slices
               best_fnd_in = 1'b1;
               best_slc_in = tbl_rd_data.slice;
               best_pos_in = s2_pos_ff;
               best_id_in  = s2_id_ff;
            end
            if (!issue && !s1_vld_ff && !s2_vld_ff) begin
               if (best_fnd_ff) begin
                  idx_in   = best_pos_ff + 6'd1;
                  state_in = ST_SHIFT;
               end else if (!recharged_ff) begin
                  recharged_in = 1'b1;
                  rc_idx_in    = '0;
                  state_in     = ST_RECHARGE;
               end else begin
                  // nothing to run even after recharge
                  state_in = ST_IDLE_RD;
               end
            end
         end

         ST_SHIFT: begin
            // read entry k, write it to k-1 in the next cycle
            issue       = (idx_ff < len_ff);
            ord_rd_addr = idx_ff;
            if (issue) begin
               idx_in = idx_ff + 6'd1;
            end
            sh_vld_in   = issue;
            sh_wpos_in  = idx_ff - 6'd1;
            ord_wr_en   = sh_vld_ff;
            ord_wr_addr = sh_wpos_ff;
            ord_wr_data = ord_q_ff;
            if (!issue && !sh_vld_ff) begin
               queued_in[SLOT_W'(best_id_ff)] = 1'b0;
               len_in = len_ff - 6'd1;
               if (req_ff.func == FUNC_PICK) begin
                  rsp_in.chosen_task  = best_id_ff;
                  rsp_in.chosen_slice = best_slc_ff;
               end
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_RECHARGE: begin
            issue       = (rc_idx_ff < SLOTS_RC);
            tbl_rd_addr = rc_idx_ff[SLOT_W-1:0];
            if (issue) begin
               rc_idx_in = rc_idx_ff + RC_ONE;
            end
            rc_vld_in   = issue;
            rc_addr_in  = rc_idx_ff[SLOT_W-1:0];
            tbl_wr_addr = rc_addr_ff;
            tbl_wr_data.slice = 8'({1'b0, tbl_rd_data.prio} + {1'b0, tbl_rd_data.slice[7:1]});
            if (rc_vld_ff && tbl_rd_data.used && (rc_addr_ff != SLOT_W'(IDLE_SLOT))) begin
               tbl_wr_en = 1'b1;
            end
            if (!issue && !rc_vld_ff) begin
               idx_in      = '0;
               best_fnd_in = 1'b0;
               best_slc_in = '0;
               state_in    = ST_SCAN;
            end
         end

         ST_IDLE_RD: begin
            tbl_rd_addr = SLOT_W'(IDLE_SLOT);
            state_in    = ST_IDLE_WR;
         end

         ST_IDLE_WR: begin
            tbl_wr_en           = 1'b1;
            tbl_wr_addr         = SLOT_W'(IDLE_SLOT);
            tbl_wr_data.slice   = {1'b0, tbl_rd_data.prio};
            rsp_in.chosen_task  = 6'(IDLE_SLOT);
            rsp_in.chosen_slice = {1'b0, tbl_rd_data.prio};
            finish              = 1'b1;
            state_in            = ST_IDLE;
         end

         ST_TICK_WR: begin
            if (tbl_rd_data.slice != 8'd0) begin
               tbl_wr_en           = 1'b1;
               tbl_wr_data.slice   = tbl_rd_data.slice - 8'd1;
               rsp_in.chosen_slice = tbl_rd_data.slice - 8'd1;
            end else begin
               rsp_in.expired = 1'b1;
            end
            finish   = 1'b1;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.ready_count = len_in;
   end

endmodule

// ===== rtl/core/mts_checker.sv =====
// ----------------------------------------------------------------------------
// mts_checker: port-level checks for the scheduler
// handshake stability and response field consistency
// ----------------------------------------------------------------------------
module mts_checker import mts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a waiting request beat keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request beat changed while waiting");

   // a held response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // one request at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // expiry only on tick, which reports no task and a zero slice
   a_expired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.expired |->
         rsp_data.chosen_task == 6'd0 && rsp_data.chosen_slice == 8'd0
         && rsp_data.error_code == ERR_OK)
      else $error("expired beat carries task or slice");

   // error beats carry no pick or tick result
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ERR_OK |->
         rsp_data.chosen_slice == 8'd0 && !rsp_data.expired)
      else $error("error beat carries result");

endmodule

bind max_timeslice_task_scheduler mts_checker u_mts_checker (.*);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the max-timeslice task scheduler
// a queue-fed driver offers request beats, a shadow slot table and ready queue
// predict each response, and a monitor compares each accepted response
// with the oldest prediction as a whole beat
module tb_top;
   import mts_pkg::*;

   localparam int SLOTS   = 64;
   localparam int Q_LIMIT = 63;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   max_timeslice_task_scheduler #(.TASK_SLOTS(SLOTS)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // clock, period 2
   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // shadow scheduler state
   logic       sh_used  [SLOTS];
   logic [6:0] sh_prio  [SLOTS];
   logic [7:0] sh_slice [SLOTS];
   logic       sh_queued[SLOTS];
   logic [5:0] sh_order [$];

   req_type pending_reqs[$];   // beats waiting for the driver
   rsp_type sched_expect[$];   // predicted responses, oldest first

   int  mismatches = 0;
   bit  send_idle_on;          // random gaps on the request side
   bit  recv_idle_on;          // random stalls on the response side
   bit  long_hold;             // receiver holds off for a long stretch
   int  send_gap;
   int  recv_gap;
   int  hold_cnt;

   // first queued entry with the largest nonzero slice, -1 if none
   function automatic int top_slice_pos();
      int   pos;
      logic [7:0] best;
      pos  = -1;
      best = 8'd0;
      foreach (sh_order[i]) begin
         if (sh_slice[sh_order[i]] > best) begin
            best = sh_slice[sh_order[i]];
            pos  = i;
         end
      end
      return pos;
   endfunction

   // advance the shadow state by one request and return the response
   function automatic rsp_type sched_predict(req_type r);
      rsp_type o;
      int      pos;
      int      id;
      o  = '0;
      id = r.task_id;
      case (r.func)
         FUNC_SET: begin
            sh_used[id]  = r.in_use;
            sh_prio[id]  = (r.priority_req == 7'd0) ? 7'd1 : r.priority_req;
            sh_slice[id] = r.slice_value;
         end
         FUNC_ENQ: begin
            if (id == IDLE_SLOT || sh_queued[id]) begin
               o.error_code = ERR_ENQ_BAD;
            end else if (sh_order.size() >= Q_LIMIT) begin
               o.error_code = ERR_Q_FULL;
            end else begin
               sh_order.push_back(id[5:0]);
               sh_queued[id] = 1'b1;
            end
         end
         FUNC_DEQ: begin
            if (!sh_queued[id]) begin
               o.error_code = ERR_DEQ_BAD;
            end else begin
               foreach (sh_order[i]) begin
                  if (sh_order[i] == id) begin
                     sh_order.delete(i);
                     break;
                  end
               end
               sh_queued[id] = 1'b0;
            end
         end
         FUNC_PICK: begin
            pos = -1;
            if (sh_order.size() != 0) begin
               pos = top_slice_pos();
               if (pos < 0) begin
                  // every queued slice is zero: recharge all in-use tasks except the idle slot
                  for (int s = 0; s < SLOTS; s++) begin
                     if (sh_used[s] && s != IDLE_SLOT)
                        sh_slice[s] = 8'(sh_prio[s] + (sh_slice[s] >> 1));
                  end
                  pos = top_slice_pos();
               end
            end
            if (pos >= 0) begin
               o.chosen_task  = sh_order[pos];
               o.chosen_slice = sh_slice[sh_order[pos]];
               sh_queued[sh_order[pos]] = 1'b0;
               sh_order.delete(pos);
            end else begin
               // empty queue or nothing rechargeable: idle task
               sh_slice[IDLE_SLOT] = {1'b0, sh_prio[IDLE_SLOT]};
               o.chosen_task  = 6'(IDLE_SLOT);
               o.chosen_slice = sh_slice[IDLE_SLOT];
            end
         end
         FUNC_TICK: begin
            if (sh_slice[id] != 8'd0)
               sh_slice[id] = sh_slice[id] - 8'd1;
            else
               o.expired = 1'b1;
            o.chosen_slice = sh_slice[id];
         end
         default: ;
      endcase
      o.ready_count = 6'(sh_order.size());
      return o;
   endfunction

   function automatic req_type make_req(logic [2:0] f, int id, int pr, int sl, bit u);
      req_type r;
      r.func         = f;
      r.task_id      = 6'(id);
      r.priority_req = 7'(pr);
      r.slice_value  = 8'(sl);
      r.in_use       = u;
      return r;
   endfunction

   // random task id, mostly from a small pool so the queue sees repeats
   function automatic int rand_id();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, 12);
   endfunction

   // driver: next beat from the pending queue, with random gap bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (send_idle_on && $urandom_range(0, 9) == 0) begin
            send_gap  <= $urandom_range(0, 13);
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_data  <= pending_reqs[0];
            sched_expect.push_back(sched_predict(pending_reqs[0]));
            void'(pending_reqs.pop_front());
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response ready: long hold, random stall bursts, or always ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
         hold_cnt  <= 0;
      end else if (long_hold) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= hold_cnt + 1;
      end else if (recv_gap > 0) begin
         recv_gap  <= recv_gap - 1;
         rsp_ready <= 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
         recv_gap  <= $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (sched_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat %p", rsp_data);
         end else begin
            if (rsp_data !== sched_expect[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected %p, got %p",
                           sched_expect[0], rsp_data);
            end
            void'(sched_expect.pop_front());
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || sched_expect.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      req_type r;
      int      k;
      int      fsel;
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      long_hold    = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
         sh_used[s] = 1'b0; sh_prio[s] = 7'd1; sh_slice[s] = 8'd0; sh_queued[s] = 1'b0;
      end
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pick, extremes, zero priority, recharge, errors
      pending_reqs.push_back(make_req(FUNC_PICK, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(FUNC_SET, 0, 0, 0, 1));
      pending_reqs.push_back(make_req(FUNC_PICK, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(FUNC_SET, 63, 127, 255, 1));
      pending_reqs.push_back(make_req(FUNC_SET, 5, 0, 0, 1));
      pending_reqs.push_back(make_req(FUNC_SET, 6, 42, 1, 0));
      pending_reqs.push_back(make_req(FUNC_ENQ, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(FUNC_ENQ, 5, 0, 0, 0));
      pending_reqs.push_back(make_req(FUNC_ENQ, 5, 0, 0, 0));
      pending_reqs.push_back(make_req(FUNC_DEQ, 9, 0, 0, 0));
      pending_reqs.push_back(make_req(FUNC_PICK, 0, 0, 0, 0));   // zero slice -> recharge
      pending_reqs.push_back(make_req(FUNC_TICK, 5, 0, 0, 0));
      pending_reqs.push_back(make_req(FUNC_TICK, 5, 0, 0, 0));   // expiry
      pending_reqs.push_back(make_req(FUNC_TICK, 63, 0, 0, 0));
      pending_reqs.push_back(make_req(FUNC_ENQ, 7, 0, 0, 0));     // unused task queued
      pending_reqs.push_back(make_req(FUNC_PICK, 0, 0, 0, 0));    // nothing rechargeable
      pending_reqs.push_back(make_req(FUNC_ENQ, 63, 0, 0, 0));
      pending_reqs.push_back(make_req(FUNC_DEQ, 7, 0, 0, 0));
      pending_reqs.push_back(make_req(FUNC_PICK, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(3'd7, 21, 85, 170, 1));     // unknown function
      pending_reqs.push_back(make_req(3'd5, 42, 42, 85, 0));
      wait_drained();

      // fill the queue to its limit while the receiver holds off
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      long_hold    = 1'b1;
      for (k = 1; k < 64; k++) pending_reqs.push_back(make_req(FUNC_ENQ, k, 0, 0, 0));
      pending_reqs.push_back(make_req(FUNC_ENQ, 6, 0, 0, 0));
      for (k = 0; k < 4; k++) pending_reqs.push_back(make_req(FUNC_PICK, 0, 0, 0, 0));
      while (hold_cnt < 300) @(posedge clock);
      long_hold = 1'b0;
      wait_drained();

      // random part: mostly well-formed scheduling traffic
      for (k = 0; k < 1200; k++) begin
         fsel = $urandom_range(0, 99);
         if (fsel < 20)
            r = make_req(FUNC_SET, rand_id(), $urandom_range(0, 127),
                         ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 255),
                         $urandom_range(0, 5) != 0);
         else if (fsel < 45) r = make_req(FUNC_ENQ, rand_id(), 0, 0, 0);
         else if (fsel < 55) r = make_req(FUNC_DEQ, rand_id(), 0, 0, 0);
         else if (fsel < 75) r = make_req(FUNC_PICK, 0, 0, 0, 0);
         else if (fsel < 97) r = make_req(FUNC_TICK, rand_id(), 0, 0, 0);
         else r = make_req(3'($urandom_range(5, 7)), 0, 0, 0, 0);
         // fields a function ignores still carry random bits
         if (r.func != FUNC_SET) begin
            r.priority_req = 7'($urandom);
            r.slice_value  = 8'($urandom);
            r.in_use       = $urandom_range(0, 1);
            if (r.func == FUNC_PICK || r.func > FUNC_TICK) r.task_id = 6'($urandom);
         end
         pending_reqs.push_back(r);
         if (k == 1000) begin
            // last stretch with no idling at all
            wait_drained();
            send_idle_on = 1'b0;
            recv_idle_on = 1'b0;
         end
      end
      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && sched_expect.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== max_timeslice_task_scheduler.f =====
rtl/core/mts_pkg.sv
rtl/core/mts_table.sv
rtl/core/max_timeslice_task_scheduler.sv
rtl/core/mts_checker.sv
tb/tb_top.sv
